// ===== src/rbd_pkg.sv =====
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SUM_W = CMP_W + 1;

    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_GET        = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic accept;
        logic rd_start;
        logic load_imm;
        logic load_ram;
        logic walk_step;
    } rbd_ctrl_t;

    typedef struct packed {
        logic needs_read;
        logic out_free;
        logic walk_last;
    } rbd_stat_t;

endpackage

// ===== src/rbd_in_if.sv =====
`timescale 1ns / 1ps

interface rbd_in_if import rbd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]         index;

    modport source (output valid, output opcode, output value, output index, input ready);
    modport sink (input valid, input opcode, input value, input index, output ready);
endinterface

// ===== src/rbd_out_if.sv =====
`timescale 1ns / 1ps

interface rbd_out_if import rbd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]         count;
    logic                       last;

    modport source (output valid, output status, output data, output count, output last,
                    input ready);
    modport sink (input valid, input status, input data, input count, input last,
                  output ready);
endinterface

// ===== src/rbd_ram.sv =====
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/rbd_ctrl.sv =====
`timescale 1ns / 1ps

module rbd_ctrl import rbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rbd_stat_t stat,
    output rbd_ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    ctrl.accept = 1'b1;
                    if (stat.needs_read)
                    begin
                        ctrl.rd_start = 1'b1;
                        state_next    = S_READ;
                    end
                    else
                    begin
                        ctrl.load_imm = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    ctrl.load_ram = 1'b1;
                    if (stat.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.walk_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/rbd_dp.sv =====
`timescale 1ns / 1ps

module rbd_dp import rbd_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rbd_ctrl_t                  ctrl,
    output rbd_stat_t                  stat,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [INDEX_W-1:0]         index,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [STATUS_W-1:0]        rsp_status,
    output logic signed [DATA_W-1:0]   rsp_data,
    output logic [COUNT_W-1:0]         rsp_count,
    output logic                       rsp_last
);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
    endfunction

    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PTR_W-1:0]      walk_slot_reg, walk_slot_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]     rsp_data_reg, rsp_data_next;
    logic [COUNT_W-1:0]    rsp_count_reg, rsp_count_next;
    logic                  rsp_last_reg, rsp_last_next;

    logic                  full;
    logic                  empty;
    logic                  idx_ok;
    logic [SUM_W-1:0]      slot_sum;
    logic [SUM_W-1:0]      slot_wrap;
    logic [PTR_W-1:0]      get_slot;
    logic [STATUS_W-1:0]   imm_status;
    logic                  push_ok;
    logic [PTR_W-1:0]      wr_addr;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [PTR_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign idx_ok = (CMP_W'(index) < CMP_W'(count_reg));

    assign slot_sum  = SUM_W'(front_reg) + SUM_W'(index);
    assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? SUM_W'(slot_sum - SUM_W'(DEPTH)) : slot_sum;
    assign get_slot  = slot_wrap[PTR_W-1:0];

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        imm_status = ST_OK;
        push_ok    = 1'b0;
        wr_addr    = back_reg;
        case (opcode)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    imm_status = ST_FULL;
                end
                else
                begin
                    push_ok    = 1'b1;
                    back_next  = ptr_inc(back_reg);
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    imm_status = ST_FULL;
                end
                else
                begin
                    push_ok    = 1'b1;
                    front_next = ptr_dec(front_reg);
                    wr_addr    = ptr_dec(front_reg);
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    imm_status = ST_EMPTY;
                end
                else
                begin
                    back_next  = ptr_dec(back_reg);
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    imm_status = ST_EMPTY;
                end
                else
                begin
                    front_next = ptr_inc(front_reg);
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_GET:
            begin
                if (!idx_ok)
                begin
                    imm_status = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                front_next = back_reg;
                count_next = '0;
            end
            OP_DUMP:
            begin
                if (empty)
                begin
                    imm_status = ST_EMPTY;
                end
            end
            default:
            begin
                imm_status = ST_OK;
            end
        endcase
    end

    assign stat.needs_read = ((opcode == OP_GET) && idx_ok) || ((opcode == OP_DUMP) && !empty);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign stat.walk_last  = (remain_reg == CNT_W'(1));

    assign ram_wr_en   = ctrl.accept && push_ok;
    assign ram_rd_en   = ctrl.rd_start || ctrl.walk_step;
    assign ram_rd_addr = ctrl.rd_start ? ((opcode == OP_GET) ? get_slot : front_reg)
                                       : walk_slot_reg;

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(value)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        walk_slot_next = walk_slot_reg;
        remain_next    = remain_reg;
        if (ctrl.rd_start)
        begin
            walk_slot_next = ptr_inc(ram_rd_addr);
            remain_next    = (opcode == OP_DUMP) ? count_reg : CNT_W'(1);
        end
        else if (ctrl.walk_step)
        begin
            walk_slot_next = ptr_inc(walk_slot_reg);
            remain_next    = CNT_W'(remain_reg - 1'b1);
        end
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_last_next   = rsp_last_reg;
        if (ctrl.load_imm)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = imm_status;
            rsp_data_next   = '0;
            rsp_count_next  = COUNT_W'(count_next);
            rsp_last_next   = 1'b1;
        end
        else if (ctrl.load_ram)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = ST_OK;
            rsp_data_next   = DATA_W'(ram_rd_data);
            rsp_count_next  = COUNT_W'(count_reg);
            rsp_last_next   = stat.walk_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            walk_slot_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
            remain_reg    <= remain_next;
            walk_slot_reg <= walk_slot_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_data   = rsp_data_reg;
    assign rsp_count  = rsp_count_reg;
    assign rsp_last   = rsp_last_reg;

endmodule

// ===== src/ring_buffer_deque.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH entries held in a circular RAM.
// The cmd channel takes one operation per transfer: push back, push front,
// pop back, pop front, get by index, clear or dump. The rsp channel returns
// status, data, the count after the operation and a last flag.
// Push, pop, clear, unused codes and failed get or dump operations give their
// single response in the cycle after the cmd transfer; a new cmd can be
// taken at the same edge as that response's transfer, so these run at one
// per cycle while rsp is ready. A valid get reads the RAM, whose read port is
// registered, so its response passes the RAM read register and the output
// register; the next cmd waits for it. A dump of N entries streams N responses
// that way, one per cycle while rsp is ready; last marks the final one.
// cmd is not taken while a get or dump is still being served.
// When rsp is stalled the response is held in the output register and cmd
// stays not ready until the register is freed.
// Reset empties the queue at once; RAM contents are left as they are.
module ring_buffer_deque import rbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rbd_in_if.sink    cmd,
    rbd_out_if.source rsp
);

    rbd_ctrl_t ctrl;
    rbd_stat_t stat;

    rbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    rbd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .opcode     (cmd.opcode),
        .value      (cmd.value),
        .index      (cmd.index),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_data   (rsp.data),
        .rsp_count  (rsp.count),
        .rsp_last   (rsp.last)
    );

endmodule

// ===== src/rbd_checker.sv =====
`timescale 1ns / 1ps

module rbd_checker import rbd_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic [OPCODE_W-1:0] cmd_opcode,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [COUNT_W-1:0]  rsp_count,
    input logic                rsp_last
);

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before its transfer");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_opcode != OP_GET && cmd_opcode != OP_DUMP
        |=> rsp_valid && rsp_last)
        else $error("single-result operation did not respond in the next cycle");

    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !cmd_ready)
        else $error("new operation taken in the middle of a dump");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(DEPTH))
        else $error("push refused while the queue was not full");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_opcode (cmd.opcode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.count),
    .rsp_last   (rsp.last)
);
